// ===== hdl/day_count_to_date_top_macros.svh =====
// ----------------------------------------------------------------------------
// Day count to date: assertion macros
// Shared property wrappers for the checker of the conversion block.
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_TO_DATE_TOP_MACROS_SVH
`define DAY_COUNT_TO_DATE_TOP_MACROS_SVH

// Check a property on every rising edge outside reset
`define DCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check a property on every rising edge, reset included
`define DCD_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed around reset");

`endif

// ===== hdl/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Day count to date: shared package
// Field widths, calendar constants, month table and the sequencer program.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  // Result field widths
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 13;
  // Day within the year, 1 .. 366
  localparam int unsigned REM_W   = 9;

  // Calendar constants
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 13'd1601;
  localparam int unsigned        YEAR_DAYS  = 365;
  localparam int unsigned        LEAP_CYCLE = 400;
  // 100 = 4 * CENT_DIV and 400 = 16 * CENT_DIV
  localparam int unsigned        CENT_DIV   = LEAP_CYCLE / 16;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;

  // Result for the day before the epoch
  localparam logic [DAY_W-1:0]   ZERO_DAY   = 5'd31;
  localparam logic [MONTH_W-1:0] ZERO_MONTH = 4'd12;
  localparam logic [YEAR_W-1:0]  ZERO_YEAR  = 13'd1600;

  // Program steps; the step counter wraps from the last back to the first
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EST,
    ST_TERMS,
    ST_SUM,
    ST_TEST,
    ST_REM,
    ST_MONTH,
    ST_EMIT
  } step_e;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_EST,
    OP_TERMS,
    OP_SUM,
    OP_TEST,
    OP_REM,
    OP_MONTH,
    OP_EMIT
  } op_e;

  // Advance condition: step on when true, else jump to the target
  typedef enum logic [2:0] {
    CD_ALWAYS,
    CD_IN_TAKEN,
    CD_YEAR_FITS,
    CD_MONTH_FOUND,
    CD_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e adv;
    step_e tgt;
  } cw_t;

  // Control store
  function automatic cw_t ucode(step_e s);
    cw_t cw;
    unique case (s)
      ST_IDLE:  cw = '{op: OP_LOAD,  adv: CD_IN_TAKEN,    tgt: ST_IDLE};
      ST_EST:   cw = '{op: OP_EST,   adv: CD_ALWAYS,      tgt: ST_EST};
      ST_TERMS: cw = '{op: OP_TERMS, adv: CD_ALWAYS,      tgt: ST_TERMS};
      ST_SUM:   cw = '{op: OP_SUM,   adv: CD_ALWAYS,      tgt: ST_SUM};
      ST_TEST:  cw = '{op: OP_TEST,  adv: CD_YEAR_FITS,   tgt: ST_TERMS};
      ST_REM:   cw = '{op: OP_REM,   adv: CD_ALWAYS,      tgt: ST_REM};
      ST_MONTH: cw = '{op: OP_MONTH, adv: CD_MONTH_FOUND, tgt: ST_MONTH};
      ST_EMIT:  cw = '{op: OP_EMIT,  adv: CD_OUT_FREE,    tgt: ST_EMIT};
    endcase
    return cw;
  endfunction

  // Month lengths, February stretched in leap years
  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dcd_if.sv =====
// ----------------------------------------------------------------------------
// Day count to date: channel interfaces
// Valid/ready channels for the day count word and the date word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcd_in_if #(
  parameter int unsigned COUNT_BITS = 20
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

interface dcd_out_if ();
  import dcd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_of_month;
  logic [MONTH_W-1:0] month_number;
  logic [YEAR_W-1:0]  year_number;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, output ready);
endinterface

`default_nettype wire

// ===== hdl/day_count_to_date_top.sv =====
// The accepted word passes the estimate step, then the shared year-correction loop (terms, sum,
//   test), run once more for each of k year-estimate corrections (0..2 at 20 count bits),
//   then the one-month-per-cycle walk over m months (0..11), then the emit step, which waits
//   for a free output. One word at a time: a new word is taken only in idle, after emitting.
// Reset: asynchronous, clears the step counter to idle and empties the output register.
// ----------------------------------------------------------------------------
// Day count to date: top level
// Microcoded converter from a day count (day 1 = 1 Jan 1601) to day, month, year.
// ----------------------------------------------------------------------------
`default_nettype none

module day_count_to_date_top #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dcd_in_if.sink    in_i,
  dcd_out_if.source out_o
);
  import dcd_pkg::*;

  // Widths: year offset, days-before sum, year count, divide-by-25 operand and quotient, products
  localparam int unsigned OFF_BITS = COUNT_BITS - 8;
  localparam int unsigned DB_W     = COUNT_BITS + 1;
  localparam int unsigned VB       = OFF_BITS + 1;
  localparam int unsigned DW       = OFF_BITS - 1;
  localparam int unsigned QW       = DW - 4;
  localparam int unsigned NP_W     = 2 * COUNT_BITS + 1;
  localparam int unsigned DP_W     = 2 * DW + 1;

  // Exact reciprocals for the count range
  localparam int unsigned S365 = COUNT_BITS + 9;
  localparam int unsigned S25  = DW + 5;
  localparam logic [COUNT_BITS:0] M365 =
    (COUNT_BITS + 1)'(((64'd1 << S365) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));
  localparam logic [DW:0] M25 =
    (DW + 1)'(((64'd1 << S25) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

  // Sequencer
  step_e pc_q, pc_d;
  cw_t   cw;
  logic  adv;

  // Datapath registers
  logic [COUNT_BITS-1:0] n_q;
  logic                  zero_q;
  logic [OFF_BITS-1:0]   off_q;
  logic [DB_W-1:0]       t365_q;
  logic [DB_W-1:0]       db_q;
  logic [QW-1:0]         qa_q;
  logic [QW-1:0]         qb_q;
  logic [REM_W-1:0]      rem_q;
  logic [MONTH_W-1:0]    m_q;
  logic                  leap_q;
  logic [YEAR_W-1:0]     year_q;

  // Output register
  logic                  out_valid_q;
  logic [DAY_W-1:0]      out_day_q;
  logic [MONTH_W-1:0]    out_month_q;
  logic [YEAR_W-1:0]     out_year_q;

  // Combinational datapath
  logic                  in_fire;
  logic                  out_free;
  logic [NP_W-1:0]       n_prod;
  logic [OFF_BITS-1:0]   off_est;
  logic [VB-1:0]         v;
  logic [DW-1:0]         div_a_op;
  logic [DW-1:0]         div_b_op;
  logic [DP_W-1:0]       div_a_prod;
  logic [DP_W-1:0]       div_b_prod;
  logic                  year_over;
  logic [DAY_W-1:0]      len;
  logic                  month_more;
  logic                  is_quad;
  logic                  is_cent;
  logic                  is_quad_cent;

  assign cw       = ucode(pc_q);
  assign in_i.ready = (cw.op == OP_LOAD);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Year estimate: count / 365 by reciprocal
  assign n_prod  = NP_W'(n_q) * NP_W'(M365);
  assign off_est = n_prod[S365 +: OFF_BITS];

  // Shared divide-by-25 pair: offset terms in the loop, leap-test terms at the test step
  assign v        = VB'(off_q) + VB'(1);
  assign div_a_op = (cw.op == OP_TERMS) ? DW'(off_q >> 2) : DW'(v >> 2);
  assign div_b_op = (cw.op == OP_TERMS) ? DW'(off_q >> 4) : DW'(v >> 4);
  assign div_a_prod = DP_W'(div_a_op) * DP_W'(M25);
  assign div_b_prod = DP_W'(div_b_op) * DP_W'(M25);

  // Estimate too high while the days before the year reach the count
  assign year_over = (off_q != '0) && (db_q >= DB_W'(n_q));

  // Leap rule on the year counted from 1600
  assign is_quad      = (v[1:0] == 2'd0);
  assign is_cent      = is_quad && (VB'(v >> 2) == VB'(qa_q) * VB'(CENT_DIV));
  assign is_quad_cent = (v[3:0] == 4'd0) && (VB'(v >> 4) == VB'(qb_q) * VB'(CENT_DIV));

  // Month walk
  assign len        = month_len(m_q, leap_q);
  assign month_more = (rem_q > REM_W'(len)) && (m_q != MONTH_LAST);

  // Decode the advance condition
  always_comb begin
    adv = 1'b1;
    case (cw.adv)
      CD_ALWAYS:      adv = 1'b1;
      CD_IN_TAKEN:    adv = in_fire;
      CD_YEAR_FITS:   adv = !year_over;
      CD_MONTH_FOUND: adv = !month_more;
      CD_OUT_FREE:    adv = out_free;
      default:        adv = 1'b1;
    endcase
  end

  // Next step: advance or jump
  always_comb begin
    pc_d = adv ? step_e'(3'(pc_q + 3'd1)) : cw.tgt;
  end

  // Step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cw.op == OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath, driven by the current control word
  always_ff @(posedge clk_i) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_fire) begin
          n_q    <= COUNT_BITS'(in_i.day_count);
          zero_q <= (COUNT_BITS'(in_i.day_count) == '0);
        end
      end
      OP_EST: begin
        off_q <= off_est;
      end
      OP_TERMS: begin
        t365_q <= DB_W'(off_q) * DB_W'(YEAR_DAYS);
        qa_q   <= div_a_prod[S25 +: QW];
        qb_q   <= div_b_prod[S25 +: QW];
      end
      OP_SUM: begin
        db_q <= t365_q + DB_W'(off_q >> 2) - DB_W'(qa_q) + DB_W'(qb_q);
      end
      OP_TEST: begin
        // step the estimate down; load the leap-test quotients for the kept year
        if (year_over) begin
          off_q <= off_q - OFF_BITS'(1);
        end
        qa_q <= div_a_prod[S25 +: QW];
        qb_q <= div_b_prod[S25 +: QW];
      end
      OP_REM: begin
        rem_q  <= REM_W'(DB_W'(n_q) - db_q);
        year_q <= EPOCH_YEAR + YEAR_W'(off_q);
        leap_q <= is_quad && (!is_cent || is_quad_cent);
        m_q    <= '0;
      end
      OP_MONTH: begin
        if (month_more) begin
          rem_q <= rem_q - REM_W'(len);
          m_q   <= m_q + MONTH_W'(1);
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_day_q   <= zero_q ? ZERO_DAY   : DAY_W'(rem_q);
          out_month_q <= zero_q ? ZERO_MONTH : m_q + MONTH_W'(1);
          out_year_q  <= zero_q ? ZERO_YEAR  : year_q;
        end
      end
    endcase
  end

  // Drive the result word
  assign out_o.valid        = out_valid_q;
  assign out_o.day_of_month = out_day_q;
  assign out_o.month_number = out_month_q;
  assign out_o.year_number  = out_year_q;

endmodule

`default_nettype wire

// ===== hdl/dcd_checker.sv =====
// ----------------------------------------------------------------------------
// Day count to date: port checker
// Watches the top-level channels for ordering, holding and range of results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "day_count_to_date_top_macros.svh"

module dcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] day_i,
  input logic [3:0] month_i
);

  // One word in flight: no second word straight after an accepted one
  `DCD_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)

  // Hold a stalled result
  `DCD_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_i && !out_ready_i |=> out_valid_i && $stable(day_i) && $stable(month_i))

  // Results are calendar dates
  `DCD_ASSERT(a_date_range, clk_i, rst_ni,
              out_valid_i |-> day_i != 5'd0 && month_i != 4'd0 && month_i <= 4'd12 &&
                              (month_i != 4'd2 || day_i <= 5'd29))

  // Nothing offered once reset has been seen at an edge
  `DCD_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind day_count_to_date_top dcd_checker u_dcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .day_i       (out_o.day_of_month),
  .month_i     (out_o.month_number)
);

`default_nettype wire
